>>> rtl/ehd_pkg.sv
// ehd_pkg: shared types, constants and calendar helpers for the holiday date block
// used by every module under rtl; no dependencies of its own

package ehd_pkg;

  localparam int YEAR_W    = 14;
  localparam int DOY_W     = 9;    // day of year, up to 366
  localparam int EYD_W     = 7;    // easter day of year, march or april only
  localparam int FRONT_STG = 8;    // computus pipeline stages
  localparam int Q_DEPTH   = 2;
  localparam int Q_AW      = $clog2(Q_DEPTH);
  localparam int Q_CW      = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    HOL_EASTER      = 3'd0,
    HOL_CARNIVAL    = 3'd1,
    HOL_GOOD_FRIDAY = 3'd2,
    HOL_ASCENSION   = 3'd3,
    HOL_WHITSUN     = 3'd4,
    HOL_CHRISTMAS   = 3'd5
  } holiday_t;

  // one year after the computus, waiting for expansion
  typedef struct packed {
    logic [EYD_W-1:0] eyd;
    logic             leap;
  } ehd_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ehd_qstat_t;

  // days before the first of the given month
  function automatic logic [DOY_W-1:0] month_start(input logic [3:0] mon, input logic leap);
    logic [DOY_W-1:0] base;
    case (mon)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && mon >= 4'd3) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

>>> rtl/easter_holiday_dates.sv
// easter_holiday_dates: top level, holiday dates for one gregorian year
// depends on ehd_pkg, ehd_front, ehd_queue, ehd_back
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------------------
//   in      | in        | in_valid / in_ready | year
//   out     | out       | out_valid/out_ready | holiday, day_of_month, month_number,
//           |           |                     | last_of_run
//
// each year word gives six result words, one per cycle while out_ready is high, so the
// single result port in the back end sets the rate at which years can be taken
// the first result word of a year passes through the eight computus stages, then the
// queue, the day-of-year stage and the output register
// synchronous active-high reset clears all valid flags, queue pointers and the holiday
// counter; payload registers are not reset
// a stall at out holds the back end; the front keeps taking years until the two-entry
// queue is full and the last computus stage holds a year, then drops in_ready

module easter_holiday_dates (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [13:0] year,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  holiday,
  output logic [4:0]  day_of_month,
  output logic [3:0]  month_number,
  output logic        last_of_run
);
  import ehd_pkg::*;

  ehd_qstat_t qstat;
  ehd_entry_t push_data;
  ehd_entry_t head;
  logic       push;
  logic       pop;

  // front: computus pipeline, easter as a day of the year plus leap flag
  ehd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .year      (year),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  // decouples the computus from the six-word expansion
  ehd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  // back: offsets per holiday, day of year to day and month, output register
  ehd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .qstat        (qstat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .holiday      (holiday),
    .day_of_month (day_of_month),
    .month_number (month_number),
    .last_of_run  (last_of_run)
  );

endmodule

>>> rtl/ehd_front.sv
// ehd_front: pipelined anonymous gregorian computus, year in, easter day of year out
// depends on ehd_pkg; feeds ehd_queue

module ehd_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [13:0]               year,
  input  ehd_pkg::ehd_qstat_t       qstat,
  output logic                      push,
  output ehd_pkg::ehd_entry_t       push_data
);
  import ehd_pkg::*;

  logic [FRONT_STG:1] v;
  logic               adv;

  // stage 1
  logic [YEAR_W-1:0] y1;
  logic [7:0]        q100_1;
  logic [9:0]        q19_1;
  // stage 2
  logic [4:0] a2;
  logic [7:0] b2;
  logic [6:0] c2;
  logic [2:0] f2;
  logic       leap2;
  // stage 3
  logic [4:0] a3;
  logic [7:0] b3;
  logic [6:0] c3;
  logic [5:0] g3;
  logic       leap3;
  // stage 4
  logic [4:0] a4;
  logic [1:0] e4;
  logic [6:0] c4;
  logic [9:0] hs4;
  logic       leap4;
  // stage 5
  logic [4:0] a5;
  logic [1:0] e5;
  logic [6:0] c5;
  logic [9:0] hs5;
  logic [4:0] q30_5;
  logic       leap5;
  // stage 6
  logic [4:0] a6;
  logic [4:0] h6;
  logic [6:0] ls6;
  logic       leap6;
  // stage 7
  logic [4:0] a7;
  logic [4:0] h7;
  logic [6:0] ls7;
  logic [3:0] q7_7;
  logic       leap7;
  // stage 8
  logic [4:0] a8;
  logic [4:0] h8;
  logic [2:0] l8;
  logic       leap8;

  logic [26:0] p100;
  logic [28:0] p19;
  logic [13:0] a_full, c_full;
  logic [8:0]  bf;
  logic [12:0] pf;
  logic [7:0]  gx;
  logic [15:0] pg;
  logic [9:0]  hs_c;
  logic [19:0] p30;
  logic [9:0]  h_full;
  logic [7:0]  ls_full;
  logic [13:0] p7;
  logic [6:0]  l_full;
  logic [9:0]  ms;
  logic [6:0]  eyd_c;

  assign adv      = !v[FRONT_STG] || !qstat.full;
  assign in_ready = adv;
  assign push     = v[FRONT_STG] && !qstat.full;

  always_comb begin
    // reciprocal multiplies stand in for /100 and /19, exact over 14 bits
    p100   = 27'(year) * 27'd5243;
    p19    = 29'(year) * 29'd27595;
    a_full = y1 - 14'(q19_1) * 14'd19;
    c_full = y1 - 14'(q100_1) * 14'd100;
    bf     = 9'(q100_1) + 9'd8;
    pf     = 13'(bf) * 13'd41;
    gx     = b2 - 8'(f2) + 8'd1;
    pg     = 16'(gx) * 16'd171;
    hs_c   = 10'(a3) * 10'd19 + 10'(b3) - 10'(b3[7:2]) - 10'(g3) + 10'd15;
    p30    = 20'(hs4) * 20'd1093;
    h_full = hs5 - 10'(q30_5) * 10'd30;
    ls_full = 8'd32 + {5'd0, e5, 1'b0} + {2'd0, c5[6:2], 1'b0}
              - 8'(h_full[4:0]) - 8'(c5[1:0]);
    p7     = 14'(ls6) * 14'd147;
    l_full = ls7 - 7'(q7_7) * 7'd7;
    ms     = 10'(a8) + 10'(h8) * 10'd11 + 10'(l8) * 10'd22;
    // day of year is that of march 22 plus h + l - 7m, plus the leap day; one sum serves march and april
    eyd_c  = 7'(h8) + 7'(l8) + 7'd81 + 7'(leap8) - ((ms >= 10'd451) ? 7'd7 : 7'd0);
  end

  assign push_data.eyd  = eyd_c;
  assign push_data.leap = leap8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[FRONT_STG-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y1     <= year;
      q100_1 <= p100[26:19];
      q19_1  <= p19[28:19];

      a2    <= a_full[4:0];
      b2    <= q100_1;
      c2    <= c_full[6:0];
      f2    <= pf[12:10];
      leap2 <= (y1[1:0] == 2'd0) && !((c_full[6:0] == 7'd0) && (q100_1[1:0] != 2'd0));

      a3    <= a2;
      b3    <= b2;
      c3    <= c2;
      g3    <= pg[14:9];
      leap3 <= leap2;

      a4    <= a3;
      e4    <= b3[1:0];
      c4    <= c3;
      hs4   <= hs_c;
      leap4 <= leap3;

      a5    <= a4;
      e5    <= e4;
      c5    <= c4;
      hs5   <= hs4;
      q30_5 <= p30[19:15];
      leap5 <= leap4;

      a6    <= a5;
      h6    <= h_full[4:0];
      ls6   <= ls_full[6:0];
      leap6 <= leap5;

      a7    <= a6;
      h7    <= h6;
      ls7   <= ls6;
      q7_7  <= p7[13:10];
      leap7 <= leap6;

      a8    <= a7;
      h8    <= h7;
      l8    <= l_full[2:0];
      leap8 <= leap7;
    end
  end

endmodule

>>> rtl/ehd_queue.sv
// ehd_queue: short register queue between computus front and date back end
// depends on ehd_pkg

module ehd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  ehd_pkg::ehd_entry_t   push_data,
  input  logic                  pop,
  output ehd_pkg::ehd_entry_t   head,
  output ehd_pkg::ehd_qstat_t   qstat
);
  import ehd_pkg::*;

  ehd_entry_t       slots [Q_DEPTH];
  logic [Q_AW-1:0]  wptr, rptr;
  logic [Q_CW-1:0]  count;

  assign head        = slots[rptr];
  assign qstat.full  = (count == Q_CW'(Q_DEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

endmodule

>>> rtl/ehd_back.sv
// ehd_back: expands one queued year into six dated words
// depends on ehd_pkg; reads the head of ehd_queue

module ehd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  ehd_pkg::ehd_entry_t   head,
  input  ehd_pkg::ehd_qstat_t   qstat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            holiday,
  output logic [4:0]            day_of_month,
  output logic [3:0]            month_number,
  output logic                  last_of_run
);
  import ehd_pkg::*;

  holiday_t         cnt;
  logic             a_valid;
  holiday_t         a_hol;
  logic [DOY_W-1:0] a_doy;
  logic             a_leap;
  logic             a_load, b_load;

  logic [DOY_W-1:0] doy_c;
  logic [3:0]       mon_c;
  logic [DOY_W-1:0] day_c;

  assign b_load = a_valid && (!out_valid || out_ready);
  assign a_load = !qstat.empty && (!a_valid || b_load);
  assign pop    = a_load && (cnt == HOL_CHRISTMAS);

  always_comb begin
    case (cnt)
      HOL_EASTER:      doy_c = 9'(head.eyd);
      HOL_CARNIVAL:    doy_c = 9'(head.eyd) - 9'd49;
      HOL_GOOD_FRIDAY: doy_c = 9'(head.eyd) - 9'd2;
      HOL_ASCENSION:   doy_c = 9'(head.eyd) + 9'd39;
      HOL_WHITSUN:     doy_c = 9'(head.eyd) + 9'd49;
      HOL_CHRISTMAS:   doy_c = head.leap ? 9'd360 : 9'd359;
      default:         doy_c = 9'(head.eyd);
    endcase
  end

  // month is the last one whose start lies below the day of year
  always_comb begin
    mon_c = 4'd1;
    for (int m = 2; m <= 12; m++) begin
      if (a_doy > month_start(4'(m), a_leap)) begin
        mon_c = 4'(m);
      end
    end
    day_c = a_doy - month_start(mon_c, a_leap);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= HOL_EASTER;
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_load) begin
        cnt <= (cnt == HOL_CHRISTMAS) ? HOL_EASTER : holiday_t'(cnt + 3'd1);
      end
      if (a_load) begin
        a_valid <= 1'b1;
      end else if (b_load) begin
        a_valid <= 1'b0;
      end
      if (b_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_hol  <= cnt;
      a_doy  <= doy_c;
      a_leap <= head.leap;
    end
    if (b_load) begin
      holiday      <= a_hol;
      day_of_month <= day_c[4:0];
      month_number <= mon_c;
      last_of_run  <= (a_hol == HOL_CHRISTMAS);
    end
  end

endmodule

>>> rtl/ehd_checker.sv
// ehd_checker: port-level assertions for easter_holiday_dates, bound to the top level
// depends on ehd_pkg and the easter_holiday_dates ports

module ehd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [13:0] year,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  holiday,
  input logic [4:0]  day_of_month,
  input logic [3:0]  month_number,
  input logic        last_of_run
);
  import ehd_pkg::*;

  // a waiting year word keeps its value
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(year))
    else $error("in word changed while waiting");

  // a stalled word keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(holiday) && $stable(day_of_month)
      && $stable(month_number) && $stable(last_of_run))
    else $error("out word changed while stalled");

  // the run closes on christmas and nowhere else
  a_last_christmas: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_of_run == (holiday == HOL_CHRISTMAS)))
    else $error("last_of_run out of step with holiday");

  // dates stay within the calendar
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> month_number >= 4'd1 && month_number <= 4'd12 && day_of_month != 5'd0)
    else $error("date out of range");

  // reset leaves no word pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid after reset");

endmodule

bind easter_holiday_dates ehd_checker u_ehd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .year         (year),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .holiday      (holiday),
  .day_of_month (day_of_month),
  .month_number (month_number),
  .last_of_run  (last_of_run)
);
